// ===== src/sif_pkg.sv =====
// ----------------------------------------------------------------------------
// sif_pkg: shared types and constants of the integer format-string formatter
// Holds the channel item structs, the controller states, the command and
// status bundles between controller and datapath, and character codes.
// ----------------------------------------------------------------------------
package sif_pkg;

    typedef struct packed {
        logic [7:0]  fmt_char;
        logic [31:0] arg_value;
        logic        final_req;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        K_NONE,
        K_BYTE,
        K_DEC,
        K_HEX
    } t_kind;

    typedef struct packed {
        logic start;
        logic mul;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_dec;
        logic in_emits;
        logic div_done;
        logic last_byte;
        logic busy;
    } t_status;

    // Decimal digits of a 32-bit magnitude
    localparam int DEC_DIGITS = 10;

    // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_TWO     = 8'h32;
    localparam logic [7:0] CHAR_EIGHT   = 8'h38;
    localparam logic [7:0] CHAR_UP_X    = 8'h58;
    localparam logic [7:0] CHAR_C       = 8'h63;
    localparam logic [7:0] CHAR_D       = 8'h64;
    localparam logic [7:0] CHAR_I       = 8'h69;
    localparam logic [7:0] CHAR_P       = 8'h70;
    localparam logic [7:0] CHAR_U       = 8'h75;
    localparam logic [7:0] CHAR_X       = 8'h78;

    // Letter bases for hex digits 10..15
    localparam logic [7:0] HEX_LOWER_BASE = 8'h57;
    localparam logic [7:0] HEX_UPPER_BASE = 8'h37;

endpackage

// ===== src/sif_dp.sv =====
// ----------------------------------------------------------------------------
// sif_dp: formatter datapath
// Decodes format characters, keeps the directive state, extracts decimal
// digits with a shared reciprocal multiplier and builds output beats.
// ----------------------------------------------------------------------------
module sif_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sif_pkg::t_cmd      i_cmd,
    input  sif_pkg::t_in_item  i_in,
    output sif_pkg::t_status   o_status,
    output sif_pkg::t_out_item o_out
);

    // directive state
    logic       r_dir;
    logic [3:0] r_fw;

    // item under work
    sif_pkg::t_kind r_kind;
    logic [7:0]     r_byte;
    logic           r_upper;
    logic [31:0]    r_arg;
    logic           r_sign_pend;
    logic [3:0]     r_body_rem;
    logic           r_fin_pend;

    // digit extraction
    logic [31:0] r_v;
    logic [63:0] r_prod;
    logic [3:0]  r_digits [sif_pkg::DEC_DIGITS];

    sif_pkg::t_out_item r_out;

    // decode
    sif_pkg::t_kind d_kind;
    logic [7:0]     d_byte;
    logic           d_neg;
    logic           d_upper;
    logic           n_dir;
    logic [3:0]     n_fw;
    logic [3:0]     d_sig;
    logic [3:0]     d_hex_cnt;
    logic [3:0]     d_rem;
    logic [31:0]    d_mag;

    always_comb begin
        d_kind  = sif_pkg::K_NONE;
        d_byte  = i_in.fmt_char;
        d_neg   = 1'b0;
        d_upper = 1'b0;
        n_dir   = r_dir;
        n_fw    = r_fw;
        if (!r_dir) begin
            if (i_in.fmt_char == sif_pkg::CHAR_PERCENT) begin
                n_dir = 1'b1;
                n_fw  = 4'd0;
            end else begin
                d_kind = sif_pkg::K_BYTE;
            end
        end else begin
            n_dir = 1'b0;
            unique case (i_in.fmt_char) inside
                sif_pkg::CHAR_D, sif_pkg::CHAR_I: begin
                    d_kind = sif_pkg::K_DEC;
                    d_neg  = i_in.arg_value[31];
                end
                sif_pkg::CHAR_U: begin
                    d_kind = sif_pkg::K_DEC;
                end
                sif_pkg::CHAR_X, sif_pkg::CHAR_P: begin
                    d_kind = sif_pkg::K_HEX;
                end
                sif_pkg::CHAR_UP_X: begin
                    d_kind  = sif_pkg::K_HEX;
                    d_upper = 1'b1;
                end
                sif_pkg::CHAR_C: begin
                    d_kind = sif_pkg::K_BYTE;
                    d_byte = i_in.arg_value[7:0];
                end
                sif_pkg::CHAR_PERCENT: begin
                    d_kind = sif_pkg::K_BYTE;
                    d_byte = sif_pkg::CHAR_PERCENT;
                end
                sif_pkg::CHAR_ZERO: begin
                    n_dir = 1'b1;
                end
                [sif_pkg::CHAR_TWO:sif_pkg::CHAR_EIGHT]: begin
                    n_dir = 1'b1;
                    n_fw  = 4'(i_in.fmt_char - sif_pkg::CHAR_ZERO);
                end
                default: begin
                    n_dir = 1'b0;
                end
            endcase
        end
        if (i_in.final_req) begin
            n_dir = 1'b0;
            n_fw  = 4'd0;
        end
    end

    // significant hex digits, at least one
    always_comb begin
        d_sig = 4'd1;
        for (int i = 1; i < 8; i++) begin
            if (i_in.arg_value[i*4 +: 4] != 4'd0) begin
                d_sig = 4'(i + 1);
            end
        end
        d_hex_cnt = (r_fw > d_sig) ? r_fw : d_sig;
        if (d_hex_cnt > 4'd8) begin
            d_hex_cnt = 4'd8;
        end
    end

    always_comb begin
        case (d_kind)
            sif_pkg::K_BYTE: d_rem = 4'd1;
            sif_pkg::K_HEX:  d_rem = d_hex_cnt;
            default:         d_rem = 4'd0;
        endcase
    end

    assign d_mag = d_neg ? (32'd0 - i_in.arg_value) : i_in.arg_value;

    // shared divide-by-ten step
    logic [28:0] w_q;
    logic [3:0]  w_q10_lo;
    logic [3:0]  w_digit;
    logic [31:0] w_mul_a;
    logic [63:0] w_prod;

    assign w_q      = r_prod[63:sif_pkg::RECIP_SHIFT];
    assign w_q10_lo = 4'({w_q[0], 3'b000}) + 4'({w_q[2:0], 1'b0});
    assign w_digit  = r_v[3:0] - w_q10_lo;
    assign w_mul_a  = i_cmd.div_step ? {3'b000, w_q} : r_v;
    assign w_prod   = 64'(w_mul_a) * 64'(sif_pkg::RECIP_10);

    // beat build
    logic [3:0] w_rd_idx;
    logic [3:0] w_nib;
    logic [7:0] w_hex_char;
    logic [7:0] w_byte;
    logic       w_last;

    assign w_rd_idx = r_body_rem - 4'd1;
    assign w_nib    = r_arg[w_rd_idx[2:0]*4 +: 4];

    always_comb begin
        if (w_nib >= 4'd10) begin
            w_hex_char = (r_upper ? sif_pkg::HEX_UPPER_BASE : sif_pkg::HEX_LOWER_BASE)
                         + 8'(w_nib);
        end else begin
            w_hex_char = sif_pkg::CHAR_ZERO + 8'(w_nib);
        end
    end

    always_comb begin
        if (r_sign_pend) begin
            w_byte = sif_pkg::CHAR_MINUS;
            w_last = 1'b0;
        end else if (r_body_rem != 4'd0) begin
            case (r_kind)
                sif_pkg::K_DEC: w_byte = sif_pkg::CHAR_ZERO + 8'(r_digits[w_rd_idx]);
                sif_pkg::K_HEX: w_byte = w_hex_char;
                default:        w_byte = r_byte;
            endcase
            w_last = (r_body_rem == 4'd1) && !r_fin_pend;
        end else begin
            w_byte = sif_pkg::CHAR_NUL;
            w_last = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= 1'b0;
            r_fw        <= 4'd0;
            r_sign_pend <= 1'b0;
            r_body_rem  <= 4'd0;
            r_fin_pend  <= 1'b0;
        end else if (i_cmd.start) begin
            r_dir       <= n_dir;
            r_fw        <= n_fw;
            r_sign_pend <= d_neg;
            r_body_rem  <= d_rem;
            r_fin_pend  <= i_in.final_req;
        end else if (i_cmd.div_step) begin
            r_body_rem <= r_body_rem + 4'd1;
        end else if (i_cmd.emit) begin
            if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_body_rem != 4'd0) begin
                r_body_rem <= r_body_rem - 4'd1;
            end else begin
                r_fin_pend <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= d_kind;
            r_byte  <= d_byte;
            r_upper <= d_upper;
            r_arg   <= i_in.arg_value;
            r_v     <= d_mag;
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.div_step) begin
            r_prod               <= w_prod;
            r_v                  <= {3'b000, w_q};
            r_digits[r_body_rem] <= w_digit;
        end
        if (i_cmd.emit) begin
            r_out.out_byte <= w_byte;
            r_out.last     <= w_last;
        end
    end

    assign o_status.in_dec    = (d_kind == sif_pkg::K_DEC);
    assign o_status.in_emits  = (d_kind != sif_pkg::K_NONE) || i_in.final_req;
    assign o_status.div_done  = (w_q == 29'd0);
    assign o_status.last_byte = w_last;
    assign o_status.busy      = r_sign_pend || (r_body_rem != 4'd0) || r_fin_pend;
    assign o_out              = r_out;

endmodule

// ===== src/sif_ctrl.sv =====
// ----------------------------------------------------------------------------
// sif_ctrl: formatter controller
// Sequences accept, digit extraction and beat output; owns the output
// valid flag.
// ----------------------------------------------------------------------------
module sif_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sif_pkg::t_status i_status,
    output sif_pkg::t_cmd    o_cmd
);

    sif_pkg::t_state r_state, n_state;
    logic            r_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sif_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            sif_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_status.in_dec) begin
                        n_state = sif_pkg::S_MUL;
                    end else if (i_status.in_emits) begin
                        n_state = sif_pkg::S_EMIT;
                    end
                end
            end
            sif_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = sif_pkg::S_DIV;
            end
            sif_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = sif_pkg::S_EMIT;
                end
            end
            sif_pkg::S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last_byte) begin
                        n_state = sif_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = sif_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == sif_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/format_string_integer_formatter.sv =====
// ----------------------------------------------------------------------------
// format_string_integer_formatter: printf-style integer formatter
// Turns a stream of format characters with argument words into a stream of
// output bytes: echoes text, expands d/i/u/x/X/p/c/%% directives and ends a
// string with a NUL terminator.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one format
//   character per beat with its argument word and final flag. Output channel
//   (o_out_valid / i_out_ready / o_out_data) gives one byte per beat; last
//   marks the final byte caused by an input beat.
//   One item is worked on at a time. Ready is high only while the controller
//   is idle; the output register lets the next item enter while the last
//   byte of the previous one still waits.
//   Items that cause no output (e.g. '%', a width digit) are done when
//   accepted. Plain chars, %c and %% emit one byte and hex emits n digits;
//   decimal runs the divide-by-ten loop (one reciprocal multiply per digit)
//   before it emits the sign and n digits. A final beat adds the terminator.
//   The output port gives one byte per cycle while the receiver is ready.
//   Reset returns to text mode with width zero and drops any pending beat.
//   A stalled receiver holds the output register and pauses the controller.
// ----------------------------------------------------------------------------
module format_string_integer_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sif_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sif_pkg::t_out_item o_out_data
);

    // command and status between controller and datapath
    sif_pkg::t_cmd    w_cmd;
    sif_pkg::t_status w_status;

    // controller: handshake, digit loop sequencing, output valid
    sif_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // datapath: decode, directive state, digit extraction, beat build
    sif_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_in     (i_in_data),
        .o_status (w_status),
        .o_out    (o_out_data)
    );

    // Idle controller never leaves bytes behind in the datapath
    a_idle_drained : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_status.busy)
        else $error("controller idle with bytes still pending");

    // Never overwrite a beat the receiver has not taken
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("output beat overwritten while stalled");

    // An item that causes no bytes leaves the block ready in the next cycle
    a_silent_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_status.in_emits) |=> o_in_ready)
        else $error("silent item did not return to idle");

endmodule

// ===== verif/format_string_integer_formatter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// format_string_integer_formatter_test: self-checking bench for the formatter
// Walks a short table of format beats through the block (extremes, every
// conversion but x, the odd directive endings), then a long run of random format
// strings. Each accepted beat is run through a behavioral formatter in the
// bench, and every output byte is checked in order against its expectation.
// Both channels idle at random; one long receiver stall and one full drain
// are forced along the way.
// ----------------------------------------------------------------------------
module format_string_integer_formatter_test;

    // Characters the package does not name
    localparam logic [7:0] CHAR_S    = "s";
    localparam logic [7:0] CHAR_NINE = "9";
    localparam logic [7:0] CHAR_ONE  = "1";
    localparam logic [7:0] CHAR_UP_A = "A";

    localparam int BEAT_TARGET  = 460;
    localparam int HOLD_OFF_AT  = 120;     // beat count that triggers the long stall
    localparam int DRAIN_AT     = 280;     // beat count that triggers the full drain
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [7:0] CONV_CHARS [9] = '{
        sif_pkg::CHAR_D, sif_pkg::CHAR_I, sif_pkg::CHAR_U, sif_pkg::CHAR_X,
        sif_pkg::CHAR_UP_X, sif_pkg::CHAR_P, sif_pkg::CHAR_C,
        sif_pkg::CHAR_PERCENT, CHAR_S};

    typedef struct {
        sif_pkg::t_in_item beat;
        bit                typed;      // expected bytes typed in below, terminator implied
        string             text;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    sif_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    sif_pkg::t_out_item o_out_data;

    // Formatter state as the bench sees it
    logic       spec_open;
    logic [3:0] spec_width;

    logic [7:0]         step_bytes[$];     // bytes caused by the beat just accepted
    sif_pkg::t_out_item pending_bytes[$];  // bytes still owed by the block, oldest first
    t_row               rows[$];

    int                 fail_count  = 0;
    int                 beats_sent  = 0;
    int                 cycle_count = 0;
    bit                 hold_off_req = 1'b0;
    bit                 tx_calm      = 1'b0;
    sif_pkg::t_out_item want;

    format_string_integer_formatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Behavioral formatter
    // ------------------------------------------------------------------------
    function automatic void push_decimal(logic [31:0] v);
        logic [7:0] digs[$];
        do begin
            digs.push_front(sif_pkg::CHAR_ZERO + 8'(v % 32'd10));
            v = v / 32'd10;
        end while (v != 32'd0);
        foreach (digs[k]) step_bytes.push_back(digs[k]);
    endfunction

    // Zero-pad to the field width, never beyond eight digits
    function automatic void push_hex(logic [31:0] v, logic [3:0] w, bit upper);
        int         sig;
        int         count;
        logic [3:0] nib;
        sig = 1;
        while (sig < 8 && (v >> (4 * sig)) != 32'd0) sig++;
        count = (int'(w) > sig) ? int'(w) : sig;
        if (count > 8) count = 8;
        for (int k = count - 1; k >= 0; k--) begin
            nib = v[4*k +: 4];
            if (nib >= 4'd10) begin
                step_bytes.push_back((upper ? sif_pkg::HEX_UPPER_BASE
                                            : sif_pkg::HEX_LOWER_BASE) + 8'(nib));
            end else begin
                step_bytes.push_back(sif_pkg::CHAR_ZERO + 8'(nib));
            end
        end
    endfunction

    // Advance the state by one format beat and collect the bytes it causes
    function automatic void format_char(sif_pkg::t_in_item it);
        logic [7:0] ch;
        ch = it.fmt_char;
        if (!spec_open) begin
            if (ch == sif_pkg::CHAR_PERCENT) begin
                spec_open  = 1'b1;
                spec_width = 4'd0;
            end else begin
                step_bytes.push_back(ch);
            end
        end else begin
            case (ch)
                sif_pkg::CHAR_D, sif_pkg::CHAR_I: begin
                    if (it.arg_value[31]) begin
                        step_bytes.push_back(sif_pkg::CHAR_MINUS);
                        push_decimal(~it.arg_value + 32'd1);
                    end else begin
                        push_decimal(it.arg_value);
                    end
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_U: begin
                    push_decimal(it.arg_value);
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_X, sif_pkg::CHAR_P: begin
                    push_hex(it.arg_value, spec_width, 1'b0);
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_UP_X: begin
                    push_hex(it.arg_value, spec_width, 1'b1);
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_C: begin
                    step_bytes.push_back(it.arg_value[7:0]);
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_PERCENT: begin
                    step_bytes.push_back(sif_pkg::CHAR_PERCENT);
                    spec_open = 1'b0;
                end
                sif_pkg::CHAR_ZERO: begin
                end
                default: begin
                    if (ch >= sif_pkg::CHAR_TWO && ch <= sif_pkg::CHAR_EIGHT) begin
                        spec_width = 4'(ch - sif_pkg::CHAR_ZERO);
                    end else begin
                        spec_open = 1'b0;
                    end
                end
            endcase
        end
        if (it.final_req) begin
            step_bytes.push_back(sif_pkg::CHAR_NUL);
            spec_open  = 1'b0;
            spec_width = 4'd0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void add_row(logic [7:0] ch, logic [31:0] arg, bit fin, bit typed,
                                    string text);
        t_row r;
        r.beat  = '{fmt_char: ch, arg_value: arg, final_req: fin};
        r.typed = typed;
        r.text  = text;
        rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'($urandom_range(0, 99));
            5:       return 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // Random beat around a chosen character; about one in twenty ends a string
    function automatic sif_pkg::t_in_item rand_beat(logic [7:0] ch);
        sif_pkg::t_in_item it;
        it.fmt_char  = ch;
        it.arg_value = pick_arg();
        it.final_req = ($urandom_range(0, 19) == 0);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one beat from a falling edge, hold it until accepted, then book the
    // bytes it owes. Leaves the caller on the next falling edge.
    task automatic send_beat(sif_pkg::t_in_item beat, bit typed, string text);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);

        // Always advance the formatter; typed rows replace its bytes
        step_bytes.delete();
        format_char(beat);
        if (typed) begin
            step_bytes.delete();
            for (int k = 0; k < text.len(); k++) step_bytes.push_back(text[k]);
            if (beat.final_req) step_bytes.push_back(sif_pkg::CHAR_NUL);
        end
        foreach (step_bytes[k]) begin
            pending_bytes.push_back('{out_byte: step_bytes[k],
                                      last: (k == step_bytes.size() - 1)});
        end
        beats_sent++;
        @(negedge i_clk);
    endtask

    // One random format token: mostly text and well-formed directives with
    // random flags, widths and arguments; the rest are broken directives.
    task automatic send_token();
        int r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) tx_calm = !tx_calm;
        if (r < 45) begin
            send_beat(rand_beat(8'($urandom_range(0, 255))), 1'b0, "");
        end else if (r < 90) begin
            send_beat(rand_beat(sif_pkg::CHAR_PERCENT), 1'b0, "");
            if ($urandom_range(0, 2) == 0) begin
                send_beat(rand_beat(sif_pkg::CHAR_ZERO), 1'b0, "");
            end
            if ($urandom_range(0, 1) == 0) begin
                send_beat(rand_beat(sif_pkg::CHAR_TWO + 8'($urandom_range(0, 6))),
                          1'b0, "");
            end
            send_beat(rand_beat(CONV_CHARS[$urandom_range(0, 8)]), 1'b0, "");
        end else begin
            send_beat(rand_beat(sif_pkg::CHAR_PERCENT), 1'b0, "");
            send_beat(rand_beat(8'($urandom_range(0, 255))), 1'b0, "");
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with short and long gaps, plus one forced stall
    // ------------------------------------------------------------------------
    initial begin
        int n;
        int m;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                // Hold off long enough for the block to back up its input
                hold_off_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 6);
                i_out_ready <= 1'b1;
                repeat (n) @(negedge i_clk);
                m = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40);
                i_out_ready <= 1'b0;
                repeat (m) @(negedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output checker: compare each accepted byte with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got byte %02h last %0b",
                         $time, o_out_data.out_byte, o_out_data.last);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.out_byte, o_out_data.out_byte);
                    fail_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $display("%0t: last mismatch on byte %02h: expected %0b, got %0b",
                             $time, want.out_byte, want.last, o_out_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("format_string_integer_formatter_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        spec_open  = 1'b0;
        spec_width = 4'd0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // Directed table: text after reset, decimal and hex extremes, every
        // conversion but x, the zero flag, 's', a stray digit, NUL and 0xFF format
        // bytes, and a final beat that lands inside an open directive.
        add_row(CHAR_UP_A,             32'h0,         1'b0, 1'b1, "A");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b1, "");
        add_row(sif_pkg::CHAR_D,       32'h8000_0000, 1'b0, 1'b1, "-2147483648");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b1, "");
        add_row(sif_pkg::CHAR_U,       32'hFFFF_FFFF, 1'b0, 1'b1, "4294967295");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b1, "");
        add_row(sif_pkg::CHAR_EIGHT,   32'h0,         1'b0, 1'b1, "");
        add_row(sif_pkg::CHAR_UP_X,    32'hDEAD_BEEF, 1'b0, 1'b1, "DEADBEEF");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_ZERO,    32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_TWO,     32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_P,       32'h0000_000A, 1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_I,       32'h7FFF_FFFF, 1'b0, 1'b1, "2147483647");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_C,       32'hFFFF_FF41, 1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(CHAR_S,                32'h1234_5678, 1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(CHAR_NINE,             32'h0,         1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_NUL,     32'hFFFF_FFFF, 1'b0, 1'b0, "");
        add_row(sif_pkg::CHAR_PERCENT, 32'h0,         1'b0, 1'b0, "");
        add_row(8'hFF,                 32'h0,         1'b1, 1'b0, "");

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[k]) send_beat(rows[k].beat, rows[k].typed, rows[k].text);

        // Random format strings, with one stray '1' directive thrown in early
        send_beat(rand_beat(sif_pkg::CHAR_PERCENT), 1'b0, "");
        send_beat(rand_beat(CHAR_ONE), 1'b0, "");
        while (beats_sent < BEAT_TARGET) begin
            if (!hold_done && beats_sent >= HOLD_OFF_AT) begin
                // Stall the receiver and keep offering beats through it
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && beats_sent >= DRAIN_AT) begin
                // Pause the sender until every owed byte has come out
                if (pending_bytes.size() != 0) begin
                    i_in_valid <= 1'b0;
                    while (pending_bytes.size() != 0) @(negedge i_clk);
                end
                drain_done = 1'b1;
            end
            send_token();
        end
        i_in_valid <= 1'b0;

        // Wait out the owed bytes, then give the block time to misbehave
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("format_string_integer_formatter_test OK");
        end else begin
            $display("format_string_integer_formatter_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== format_string_integer_formatter.f =====
src/sif_pkg.sv
src/sif_dp.sv
src/sif_ctrl.sv
src/format_string_integer_formatter.sv
verif/format_string_integer_formatter_test.sv
